### hw/rtl/acl_entry_order_checker_unit_macros.svh
// Assertion macros for the access-control record checker.
// Used by the top-level RTL file through `include; no other dependencies.
`ifndef ACL_ENTRY_ORDER_CHECKER_UNIT_MACROS_SVH
`define ACL_ENTRY_ORDER_CHECKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Checked property, disabled while reset is asserted.
`define ACL_EOC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked property, active during reset too.
`define ACL_EOC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ACL_EOC_ASSERT(lbl, clk, rstn, prop, msg)
`define ACL_EOC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### hw/rtl/acl_eoc_pkg.sv
// Shared types and constants for the access-control record checker.
// No dependencies.
package acl_eoc_pkg;

  localparam int unsigned MaxEntries  = 1024;
  localparam int unsigned CntW        = $clog2(MaxEntries + 1);
  localparam int unsigned EntryCountW = 11;
  localparam int unsigned ModeW       = 9;

  localparam logic [31:0] ExpVersionRst = 32'd2;

  localparam logic FUNC_HEADER = 1'b0;
  localparam logic FUNC_ENTRY  = 1'b1;

  localparam logic [15:0] TAG_USER_OWNER  = 16'd1;
  localparam logic [15:0] TAG_USER        = 16'd2;
  localparam logic [15:0] TAG_GROUP_OWNER = 16'd4;
  localparam logic [15:0] TAG_GROUP       = 16'd8;
  localparam logic [15:0] TAG_MASK        = 16'd16;
  localparam logic [15:0] TAG_OTHER       = 16'd32;

  typedef enum logic [2:0] {
    PH_USER_OWNER,
    PH_USERS,
    PH_GROUPS,
    PH_OTHER,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic        func;
    logic [31:0] version;
    logic [15:0] tag;
    logic [15:0] perm;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic                   status;
    logic [EntryCountW-1:0] entry_count;
    logic                   extended;
    logic [ModeW-1:0]       access_mode;
    logic                   done_res;
  } out_item_t;

  // Control between the input stage and the checker core
  typedef struct packed {
    logic step;  // item in the input register is consumed this cycle
    logic emit;  // ... and it closes a record, result goes to the output register
  } step_ctl_t;

endpackage

### hw/rtl/acl_entry_order_checker_unit.sv
// Top level of the access-control record checker: input register, ordering
// core and result register. Depends on acl_eoc_pkg and the assertion macros.
//
// Usage: a record is a header item (func 0, version) followed by entry items
// (func 1, tag, perm); the item with last set closes it. Items arrive on the
// in_* valid/ready channel, one transfer per cycle at full rate. Each record
// produces exactly one result on the out_* channel, taken from the state left
// by its last item; non-last items produce nothing.
// An item is registered in the input register on transfer and checked there
// by the ordering core; a closing item's result is then loaded into the
// result register, which drives out_valid_o.
// Throughput: one item per cycle while items can advance; the ordering core
// updates its state once per item. While the result register is full and
// out_ready_i is low, non-last items still advance; a last item waits in the
// input register, and in_ready_o drops once that register cannot drain.
// Reset: rst_ni clears both registers' valid flags, the record state, and
// sets the expected version to 2. cfg_we_i/cfg_wdata_i write the expected
// version; write it only while no record is in flight.
`include "acl_entry_order_checker_unit_macros.svh"

module acl_entry_order_checker_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [31:0]            cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  acl_eoc_pkg::in_item_t  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output acl_eoc_pkg::out_item_t out_data_o
);

  logic                   item_valid;
  acl_eoc_pkg::in_item_t  item;
  logic                   out_free;
  logic                   adv;
  acl_eoc_pkg::step_ctl_t ctl;
  acl_eoc_pkg::out_item_t res;

  // a closing item needs a free result register to move on
  assign adv      = item_valid && (!item.last || out_free);
  assign ctl.step = adv;
  assign ctl.emit = adv && item.last;

  acl_eoc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .adv_i      (adv),
    .valid_o    (item_valid),
    .item_o     (item)
  );

  acl_eoc_order u_order (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctl_i       (ctl),
    .item_i      (item),
    .res_o       (res)
  );

  acl_eoc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (ctl.emit),
    .data_i      (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `ACL_EOC_ASSERT(a_emit_shows, clk_i, rst_ni, ctl.emit |=> out_valid_o, "result lost after closing item")
  `ACL_EOC_ASSERT(a_rose_from_emit, clk_i, rst_ni, $rose(out_valid_o) |-> $past(ctl.emit), "result without closing item")
  `ACL_EOC_ASSERT(a_stall_holds_item, clk_i, rst_ni, !in_ready_o |-> (item_valid && item.last && !out_free), "input stalled without a blocked closing item")
  `ACL_EOC_ASSERT(a_emit_only_last, clk_i, rst_ni, ctl.step && !item.last |-> !ctl.emit, "result from a non-closing item")

endmodule

### hw/rtl/acl_eoc_in_stage.sv
// Input register for item transfers into the record checker.
// Depends on acl_eoc_pkg.
module acl_eoc_in_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  acl_eoc_pkg::in_item_t in_data_i,
  input  logic                 adv_i,
  output logic                 valid_o,
  output acl_eoc_pkg::in_item_t item_o
);

  logic                  valid_q, valid_d;
  acl_eoc_pkg::in_item_t item_q;
  logic                  load;

  assign in_ready_o = !valid_q || adv_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !adv_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### hw/rtl/acl_eoc_order.sv
// Ordering machine and record accumulators of the record checker.
// Holds the version register; depends on acl_eoc_pkg.
module acl_eoc_order (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [31:0]            cfg_wdata_i,
  input  acl_eoc_pkg::step_ctl_t ctl_i,
  input  acl_eoc_pkg::in_item_t  item_i,
  output acl_eoc_pkg::out_item_t res_o
);

  localparam logic [acl_eoc_pkg::CntW-1:0] MaxCnt =
    acl_eoc_pkg::CntW'(acl_eoc_pkg::MaxEntries);

  logic [31:0]                    exp_q;
  acl_eoc_pkg::phase_e            ph_q, ph_d, ph_c;
  logic                           named_q, named_d, named_c;
  logic                           err_q, err_d, err_c;
  logic                           ext_q, ext_d, ext_c;
  logic [acl_eoc_pkg::ModeW-1:0]  mode_q, mode_d, mode_c;
  logic [acl_eoc_pkg::CntW-1:0]   cnt_q, cnt_d, cnt_c;
  logic [2:0]                     p;
  logic                           bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= acl_eoc_pkg::ExpVersionRst;
    end else if (cfg_we_i) begin
      exp_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= acl_eoc_pkg::PH_USER_OWNER;
      named_q <= 1'b0;
      err_q   <= 1'b0;
      ext_q   <= 1'b0;
      mode_q  <= '0;
      cnt_q   <= '0;
    end else if (ctl_i.step) begin
      ph_q    <= ph_d;
      named_q <= named_d;
      err_q   <= err_d;
      ext_q   <= ext_d;
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    p       = item_i.perm[2:0];
    ph_c    = ph_q;
    named_c = named_q;
    err_c   = err_q;
    ext_c   = ext_q;
    mode_c  = mode_q;
    cnt_c   = cnt_q;

    if (item_i.func == acl_eoc_pkg::FUNC_HEADER) begin
      // header restarts the record
      ph_c    = acl_eoc_pkg::PH_USER_OWNER;
      named_c = 1'b0;
      ext_c   = 1'b0;
      mode_c  = '0;
      cnt_c   = '0;
      err_c   = (item_i.version != exp_q);
    end else if (cnt_q >= MaxCnt) begin
      err_c = 1'b1;
    end else begin
      cnt_c = cnt_q + 1'b1;
      case (item_i.tag)
        acl_eoc_pkg::TAG_USER_OWNER: begin
          if (ph_q == acl_eoc_pkg::PH_USER_OWNER) ph_c = acl_eoc_pkg::PH_USERS;
          else err_c = 1'b1;
          mode_c = mode_q | {p, 6'd0};
        end
        acl_eoc_pkg::TAG_USER: begin
          if (ph_q != acl_eoc_pkg::PH_USERS) err_c = 1'b1;
          named_c = 1'b1;
          ext_c   = 1'b1;
        end
        acl_eoc_pkg::TAG_GROUP_OWNER: begin
          if (ph_q == acl_eoc_pkg::PH_USERS) ph_c = acl_eoc_pkg::PH_GROUPS;
          else err_c = 1'b1;
          mode_c = mode_q | {3'd0, p, 3'd0};
        end
        acl_eoc_pkg::TAG_GROUP: begin
          if (ph_q != acl_eoc_pkg::PH_GROUPS) err_c = 1'b1;
          named_c = 1'b1;
          ext_c   = 1'b1;
        end
        acl_eoc_pkg::TAG_MASK: begin
          if (ph_q == acl_eoc_pkg::PH_GROUPS) ph_c = acl_eoc_pkg::PH_OTHER;
          else err_c = 1'b1;
          // mask replaces the group-owner bits
          mode_c = {mode_q[8:6], p, mode_q[2:0]};
          ext_c  = 1'b1;
        end
        acl_eoc_pkg::TAG_OTHER: begin
          // mask may be skipped only when no named entry was seen
          if (ph_q == acl_eoc_pkg::PH_OTHER ||
              (ph_q == acl_eoc_pkg::PH_GROUPS && !named_q)) begin
            ph_c = acl_eoc_pkg::PH_DONE;
          end else begin
            err_c = 1'b1;
          end
          mode_c = mode_q | {6'd0, p};
        end
        default: begin
          err_c = 1'b1;
        end
      endcase
    end

    bad = err_c || ((cnt_c != '0) && (ph_c != acl_eoc_pkg::PH_DONE));

    res_o.status      = bad;
    res_o.entry_count = acl_eoc_pkg::EntryCountW'(cnt_c);
    res_o.extended    = !bad && ext_c;
    res_o.access_mode = bad ? '0 : mode_c;
    res_o.done_res    = 1'b1;

    if (ctl_i.emit) begin
      ph_d    = acl_eoc_pkg::PH_USER_OWNER;
      named_d = 1'b0;
      err_d   = 1'b0;
      ext_d   = 1'b0;
      mode_d  = '0;
      cnt_d   = '0;
    end else begin
      ph_d    = ph_c;
      named_d = named_c;
      err_d   = err_c;
      ext_d   = ext_c;
      mode_d  = mode_c;
      cnt_d   = cnt_c;
    end
  end

endmodule

### hw/rtl/acl_eoc_out_stage.sv
// Result register for result transfers out of the record checker.
// Depends on acl_eoc_pkg.
module acl_eoc_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  acl_eoc_pkg::out_item_t data_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output acl_eoc_pkg::out_item_t out_data_o
);

  logic                   valid_q, valid_d;
  acl_eoc_pkg::out_item_t data_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

### test/tb_acl_entry_order_checker_unit.sv
// Self-checking testbench for acl_entry_order_checker_unit: directed records,
// version register, entry limit, back-pressure and random record streams.
// Depends on acl_eoc_pkg and the unit's RTL; predicts each result internally.
`timescale 1ns / 100ps

module tb_acl_entry_order_checker_unit;
  import acl_eoc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SLOW} rx_mode_e;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;

  acl_entry_order_checker_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Record tracking state, mirrors the block after reset
  logic [31:0] exp_version = ExpVersionRst;
  phase_e      rec_phase   = PH_USER_OWNER;
  logic        rec_named   = 1'b0;
  logic        rec_err     = 1'b0;
  logic        rec_ext     = 1'b0;
  logic [8:0]  rec_mode    = '0;
  logic [10:0] rec_count   = '0;

  out_item_t verdict_q[$];

  int errors          = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int cfg_writes      = 0;
  int cycle_cnt       = 0;

  logic     tx_bursty     = 1'b0;
  int       tx_burst_left = 0;
  rx_mode_e rx_mode       = RX_ALWAYS;
  logic [7:0] rx_pat      = 8'b1101_0110;
  int       hold_req      = 0;
  int       hold_ack      = 0;
  int       hold_left     = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i);
    $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt, verdict_q.size());
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Record predictor
  // ---------------------------------------------------------------------------
  task automatic clear_record_state();
    rec_phase = PH_USER_OWNER;
    rec_named = 1'b0;
    rec_err   = 1'b0;
    rec_ext   = 1'b0;
    rec_mode  = '0;
    rec_count = '0;
  endtask

  task automatic advance_record(in_item_t it);
    logic [2:0] p;
    logic       bad;
    out_item_t  r;
    p = it.perm[2:0];
    if (it.func == FUNC_HEADER) begin
      clear_record_state();
      if (it.version != exp_version) rec_err = 1'b1;
    end else if (rec_count >= MaxEntries) begin
      rec_err = 1'b1;  // count saturates
    end else begin
      rec_count = rec_count + 1'b1;
      case (it.tag)
        TAG_USER_OWNER: begin
          if (rec_phase == PH_USER_OWNER) rec_phase = PH_USERS;
          else rec_err = 1'b1;
          rec_mode[8:6] = rec_mode[8:6] | p;
        end
        TAG_USER: begin
          if (rec_phase != PH_USERS) rec_err = 1'b1;
          rec_named = 1'b1;
          rec_ext   = 1'b1;
        end
        TAG_GROUP_OWNER: begin
          if (rec_phase == PH_USERS) rec_phase = PH_GROUPS;
          else rec_err = 1'b1;
          rec_mode[5:3] = rec_mode[5:3] | p;
        end
        TAG_GROUP: begin
          if (rec_phase != PH_GROUPS) rec_err = 1'b1;
          rec_named = 1'b1;
          rec_ext   = 1'b1;
        end
        TAG_MASK: begin
          if (rec_phase == PH_GROUPS) rec_phase = PH_OTHER;
          else rec_err = 1'b1;
          rec_mode[5:3] = p;  // mask replaces the group bits
          rec_ext = 1'b1;
        end
        TAG_OTHER: begin
          if (rec_phase == PH_OTHER || (rec_phase == PH_GROUPS && !rec_named))
            rec_phase = PH_DONE;
          else rec_err = 1'b1;
          rec_mode[2:0] = rec_mode[2:0] | p;
        end
        default: rec_err = 1'b1;
      endcase
    end
    if (it.last) begin
      bad           = rec_err || (rec_count != 0 && rec_phase != PH_DONE);
      r.status      = bad;
      r.entry_count = rec_count;
      r.extended    = !bad && rec_ext;
      r.access_mode = bad ? 9'd0 : rec_mode;
      r.done_res    = 1'b1;
      verdict_q.push_back(r);
      clear_record_state();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string fld, logic [31:0] want_v, logic [31:0] got_v);
    errors++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, want_v, got_v);
  endtask

  out_item_t want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      results_checked++;
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing, actual %h",
                 $time, out_data_o);
      end else begin
        want = verdict_q.pop_front();
        if (out_data_o.status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(out_data_o.status));
        if (out_data_o.entry_count !== want.entry_count)
          report_mismatch("entry_count", 32'(want.entry_count),
                          32'(out_data_o.entry_count));
        if (out_data_o.extended !== want.extended)
          report_mismatch("extended", 32'(want.extended), 32'(out_data_o.extended));
        if (out_data_o.access_mode !== want.access_mode)
          report_mismatch("access_mode", 32'(want.access_mode),
                          32'(out_data_o.access_mode));
        if (out_data_o.done_res !== want.done_res)
          report_mismatch("done_res", 32'(want.done_res), 32'(out_data_o.done_res));
      end
    end
  end

  // Result side stalls; a hold-off request forces a long stall
  always @(posedge clk_i) begin
    if (hold_ack != hold_req) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    rx_pat = {rx_pat[6:0], rx_pat[7]};
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS:  out_ready_i <= 1'b1;
        RX_RANDOM:  out_ready_i <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: out_ready_i <= rx_pat[0];
        default:    out_ready_i <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_item_t make_item(logic func, logic [31:0] ver, logic [15:0] tag,
                                         logic [15:0] perm, logic last);
    in_item_t it;
    it.func    = func;
    it.version = ver;
    it.tag     = tag;
    it.perm    = perm;
    it.last    = last;
    return it;
  endfunction

  function automatic logic [15:0] pick_tag();
    case ($urandom_range(0, 5))
      0:       return TAG_USER_OWNER;
      1:       return TAG_USER;
      2:       return TAG_GROUP_OWNER;
      3:       return TAG_GROUP;
      4:       return TAG_MASK;
      default: return TAG_OTHER;
    endcase
  endfunction

  // One transfer; valid stays up across a burst, drops for the gaps
  task automatic send_item(in_item_t it);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    advance_record(it);
    items_sent++;
    if (tx_bursty) begin
      if (tx_burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat (($urandom_range(0, 9) == 0) ? 20 : $urandom_range(1, 5)) @(posedge clk_i);
        tx_burst_left = $urandom_range(1, 12);
      end else begin
        tx_burst_left--;
      end
    end
  endtask

  task automatic send_header(logic [31:0] ver, logic last);
    send_item(make_item(FUNC_HEADER, ver, '0, '0, last));
  endtask

  task automatic send_entry(logic [15:0] tag, logic [15:0] perm, logic last);
    send_item(make_item(FUNC_ENTRY, '0, tag, perm, last));
  endtask

  // Sender pauses until every expected result is back, then lets the pipe settle
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_expected_version(logic [31:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    exp_version = v;
    cfg_writes++;
  endtask

  // Mostly well-formed records with random content; some get broken on purpose
  task automatic send_random_record();
    in_item_t q[$];
    in_item_t tmp;
    int       i, j, n;
    logic [31:0] ver;
    ver = ($urandom_range(0, 9) == 0) ? $urandom : exp_version;
    q.push_back(make_item(FUNC_HEADER, ver, 16'($urandom), 16'($urandom), 1'b0));
    q.push_back(make_item(FUNC_ENTRY, $urandom, TAG_USER_OWNER, 16'($urandom), 1'b0));
    repeat ($urandom_range(0, 3)) q.push_back(make_item(FUNC_ENTRY, $urandom, TAG_USER,
                                                        16'($urandom), 1'b0));
    q.push_back(make_item(FUNC_ENTRY, $urandom, TAG_GROUP_OWNER, 16'($urandom), 1'b0));
    n = $urandom_range(0, 3);
    repeat (n) q.push_back(make_item(FUNC_ENTRY, $urandom, TAG_GROUP, 16'($urandom), 1'b0));
    if (q.size() > 4 || $urandom_range(0, 2) == 0)
      q.push_back(make_item(FUNC_ENTRY, $urandom, TAG_MASK, 16'($urandom), 1'b0));
    q.push_back(make_item(FUNC_ENTRY, $urandom, TAG_OTHER, 16'($urandom), 1'b0));
    i = $urandom_range(1, q.size() - 1);
    j = $urandom_range(1, q.size() - 1);
    case ($urandom_range(0, 15))
      0: q[i].tag = 16'($urandom_range(0, 65535));
      1: begin
        tmp  = q[i];
        q[i] = q[j];
        q[j] = tmp;
      end
      2: q.delete(i);
      3: begin
        n = $urandom_range(1, q.size() - 1);
        while (q.size() > n) q.delete(q.size() - 1);
      end
      4: q.delete(0);
      5: q.insert(i, q[j]);
      6: q.insert(i, make_item(FUNC_HEADER, exp_version, 16'($urandom), 16'($urandom),
                              1'b0));
      default: ;
    endcase
    foreach (q[k]) q[k].last = (k == q.size() - 1);
    // early close splits it
    if ($urandom_range(0, 19) == 0 && i < q.size()) q[i - 1].last = 1'b1;
    foreach (q[k]) send_item(q[k]);
  endtask

  task automatic send_noise_item();
    logic func;
    func = 1'($urandom_range(0, 1));
    send_item(make_item(func, ($urandom_range(0, 1) != 0) ? exp_version : $urandom,
                        ($urandom_range(0, 1) != 0) ? pick_tag() : 16'($urandom),
                        16'($urandom), 1'($urandom_range(0, 1))));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_records();
    tx_bursty = 1'b1;
    rx_mode   = RX_RANDOM;
    // entries right after reset, no header; every tag, perm extremes
    send_entry(TAG_USER_OWNER, 16'hFFFF, 1'b0);
    send_entry(TAG_USER, 16'h0000, 1'b0);
    send_entry(TAG_GROUP_OWNER, 16'h0005, 1'b0);
    send_entry(TAG_GROUP, 16'h0002, 1'b0);
    send_entry(TAG_MASK, 16'h0003, 1'b0);
    send_entry(TAG_OTHER, 16'hFFFF, 1'b1);
    // empty record, matching and mismatching version
    send_header(ExpVersionRst, 1'b1);
    send_header(ExpVersionRst + 1, 1'b1);
    // header in mid-record restarts it
    send_header(ExpVersionRst, 1'b0);
    send_entry(TAG_USER_OWNER, 16'h0007, 1'b0);
    send_entry(TAG_GROUP_OWNER, 16'h0001, 1'b0);
    send_header(ExpVersionRst, 1'b0);
    send_entry(TAG_USER_OWNER, 16'h0006, 1'b0);
    send_entry(TAG_GROUP_OWNER, 16'h0004, 1'b0);
    send_entry(TAG_OTHER, 16'h0001, 1'b1);
    // entry after the closing other
    send_header(ExpVersionRst, 1'b0);
    send_entry(TAG_USER_OWNER, 16'h0007, 1'b0);
    send_entry(TAG_GROUP_OWNER, 16'h0007, 1'b0);
    send_entry(TAG_OTHER, 16'h0007, 1'b0);
    send_entry(TAG_USER_OWNER, 16'h0007, 1'b1);
    // closed before other
    send_header(ExpVersionRst, 1'b0);
    send_entry(TAG_USER_OWNER, 16'h0003, 1'b0);
    send_entry(TAG_GROUP_OWNER, 16'h0003, 1'b1);
    // illegal tag
    send_header(ExpVersionRst, 1'b0);
    send_entry(TAG_USER_OWNER, 16'h0001, 1'b0);
    send_entry(16'hFFFF, 16'h0001, 1'b1);
    wait_drain();
  endtask

  task automatic test_version_register();
    logic [31:0] vals[3];
    vals[0] = 32'h0000_0000;
    vals[1] = 32'hFFFF_FFFF;
    vals[2] = $urandom;
    foreach (vals[i]) begin
      write_expected_version(vals[i]);
      send_header(vals[i], 1'b1);
      send_header(~vals[i], 1'b1);
      send_header(vals[i], 1'b0);
      send_entry(TAG_USER_OWNER, 16'($urandom), 1'b0);
      send_entry(TAG_GROUP_OWNER, 16'($urandom), 1'b0);
      send_entry(TAG_OTHER, 16'($urandom), 1'b1);
      wait_drain();
    end
    write_expected_version(ExpVersionRst);
  endtask

  // Full-length well-formed record that then runs past the entry limit
  task automatic test_entry_limit();
    tx_bursty = 1'b0;
    rx_mode   = RX_ALWAYS;
    send_header(exp_version, 1'b0);
    send_entry(TAG_USER_OWNER, 16'($urandom), 1'b0);
    repeat (MaxEntries - 4) send_entry(TAG_USER, 16'($urandom), 1'b0);
    send_entry(TAG_GROUP_OWNER, 16'($urandom), 1'b0);
    send_entry(TAG_MASK, 16'($urandom), 1'b0);
    send_entry(TAG_OTHER, 16'($urandom), 1'b0);
    send_entry(TAG_OTHER, 16'($urandom), 1'b0);
    send_entry(TAG_USER, 16'($urandom), 1'b1);
    wait_drain();
  endtask

  // Result side holds off while the sender keeps offering closing items
  task automatic test_backpressure();
    tx_bursty = 1'b0;
    rx_mode   = RX_ALWAYS;
    hold_req++;
    repeat (30) begin
      send_header(exp_version, 1'b1);
      send_header(exp_version, 1'b0);
      send_entry(TAG_USER_OWNER, 16'($urandom), 1'b0);
      send_entry(TAG_GROUP_OWNER, 16'($urandom), 1'b0);
      send_entry(TAG_OTHER, 16'($urandom), 1'b1);
    end
    wait_drain();
  endtask

  task automatic test_random_records(int n_items, logic bursty, rx_mode_e mode);
    int stop_at;
    write_expected_version(($urandom_range(0, 3) == 0) ? ExpVersionRst : $urandom);
    tx_bursty = bursty;
    rx_mode   = mode;
    stop_at   = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) send_noise_item();
      else send_random_record();
    end
    send_header(exp_version, 1'b1);  // close any open record before the next write
    wait_drain();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_records();
    test_version_register();
    test_entry_limit();
    test_backpressure();
    test_random_records(250, 1'b1, RX_RANDOM);
    test_random_records(200, 1'b0, RX_PATTERN);
    test_random_records(200, 1'b1, RX_SLOW);
    repeat (8) @(posedge clk_i);
    $display("Run: %0d input transfers, %0d results checked, %0d version writes",
             items_sent, results_checked, cfg_writes);
    $display("Covered tag ordering, version match, entry limit, stalls and random records");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/acl_eoc_pkg.sv
hw/rtl/acl_eoc_in_stage.sv
hw/rtl/acl_eoc_order.sv
hw/rtl/acl_eoc_out_stage.sv
hw/rtl/acl_entry_order_checker_unit.sv
test/tb_acl_entry_order_checker_unit.sv
